// File: rtl/urs13_pkg.sv
// Shared types and constants of the 13-bit uniform rejection sampler.
package urs13_pkg;

	localparam int SAMPLE_BITS = 13;
	localparam int BYTE_W      = 8;
	localparam int BUF_W       = SAMPLE_BITS - 1;
	localparam int WIDE_W      = BUF_W + BYTE_W;
	localparam int HELD_W      = $clog2(SAMPLE_BITS);
	localparam int SUM_W       = $clog2(WIDE_W + 1);
	localparam int MOD_W       = 14;
	localparam int TGT_W       = 9;
	localparam int IDX_W       = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = MOD_W;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TARGET  = CFG_IDX_W'(1);

	localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(7681);
	localparam logic [TGT_W-1:0] TARGET_RESET  = TGT_W'(256);

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              restart;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] coeff;
		logic [IDX_W-1:0]       coeff_index;
		logic                   last;
	} result_t;

	typedef struct packed {
		logic [MOD_W-1:0] modulus;
		logic [TGT_W-1:0] target_count;
	} cfg_t;

endpackage

// File: rtl/urs13_core.sv
// Bit buffer, candidate cut, acceptance test and coefficient count.
module urs13_core import urs13_pkg::*; #(
	parameter int MAX_COEFFS = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t res
);

	localparam int CW = $clog2(MAX_COEFFS + 1);
	localparam int TW = (CW > TGT_W) ? CW : TGT_W;

	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] held_q;
	logic [CW-1:0]     cnt_q;

	logic [BUF_W-1:0]  buf_in;
	logic [HELD_W-1:0] held_in;
	logic [CW-1:0]     cnt_in;
	logic [TW-1:0]     cnt_ext;
	logic [TW-1:0]     cnt_inc;
	logic [TW-1:0]     tgt_ext;
	logic [TW-1:0]     tgt_eff;
	logic              done;
	logic [WIDE_W-1:0] wide;
	logic [SUM_W-1:0]  held_sum;
	logic              take;
	logic [SAMPLE_BITS-1:0] cand;
	logic              keep;
	logic [BUF_W-1:0]  buf_d;
	logic [HELD_W-1:0] held_d;
	logic [CW-1:0]     cnt_d;

	always_comb begin
		// restart clears the state before this item is taken
		buf_in  = item.restart ? '0 : buf_q;
		held_in = item.restart ? '0 : held_q;
		cnt_in  = item.restart ? '0 : cnt_q;

		cnt_ext = TW'(cnt_in);
		cnt_inc = cnt_ext + TW'(1);
		tgt_ext = TW'(cfg.target_count);
		tgt_eff = (tgt_ext > TW'(MAX_COEFFS)) ? TW'(MAX_COEFFS) : tgt_ext;
		done    = cnt_ext >= tgt_eff;

		wide     = WIDE_W'(buf_in) | (WIDE_W'(item.data_byte) << held_in);
		held_sum = SUM_W'(held_in) + SUM_W'(BYTE_W);
		take     = held_sum >= SUM_W'(SAMPLE_BITS);
		cand     = wide[SAMPLE_BITS-1:0];
		keep     = !done && take && ({1'b0, cand} < cfg.modulus);

		if (done) begin
			// polynomial complete: hold the buffer
			buf_d  = buf_in;
			held_d = held_in;
		end else if (take) begin
			buf_d  = BUF_W'(wide[WIDE_W-1:SAMPLE_BITS]);
			held_d = HELD_W'(held_sum - SUM_W'(SAMPLE_BITS));
		end else begin
			buf_d  = wide[BUF_W-1:0];
			held_d = HELD_W'(held_sum);
		end
		cnt_d = keep ? cnt_inc[CW-1:0] : cnt_in;

		res_valid       = keep;
		res.coeff       = cand;
		res.coeff_index = cnt_ext[IDX_W-1:0];
		res.last        = cnt_inc == tgt_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			held_q <= '0;
			cnt_q  <= '0;
		end else if (advance) begin
			buf_q  <= buf_d;
			held_q <= held_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// File: rtl/uniform_13bit_rejection_sampler.sv
// Top level of the 13-bit uniform rejection sampler.
//
// Usage:
//  - Byte channel (byte_valid, byte_stall, data_byte, restart): one random
//    byte per item, read LSB first as one continuous bit stream. restart
//    clears the bit buffer and the coefficient count before its byte.
//  - Coefficient channel (coeff_valid, coeff_stall, coeff, coeff_index,
//    last): an item for each 13-bit candidate below the modulus.
//  - Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0
//    modulus, index 1 target count; other indexes are ignored. Write while
//    idle only.
//  - Throughput: one byte per cycle while coeff_stall is not held. A byte is
//    registered on acceptance, and its coefficient is registered in the output
//    register when that byte advances; the bit buffer update sets the rate.
//  - Once the target count is reached, bytes are taken and dropped until a
//    restart.
//  - Reset clears the buffer and count and loads modulus 7681, target 256.
//  - When coeff_stall is held on a valid output item, the output register holds
//    it, a byte in the input register waits there and byte_stall rises.
module uniform_13bit_rejection_sampler import urs13_pkg::*; #(
	parameter int MAX_COEFFS = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [BYTE_W-1:0]      data_byte,
	input  logic                   restart,
	output logic                   coeff_valid,
	input  logic                   coeff_stall,
	output logic [SAMPLE_BITS-1:0] coeff,
	output logic [IDX_W-1:0]       coeff_index,
	output logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    advance;
	logic    res_valid;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus      <= MODULUS_RESET;
			cfg_q.target_count <= TARGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODULUS: cfg_q.modulus      <= cfg_data[MOD_W-1:0];
				REG_TARGET:  cfg_q.target_count <= cfg_data[TGT_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the held byte whenever the output register can take a result
	assign advance    = valid_s1 && (!out_valid_q || !coeff_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1.data_byte <= data_byte;
			item_s1.restart   <= restart;
		end
	end

	urs13_core #(
		.MAX_COEFFS(MAX_COEFFS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!coeff_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign coeff_valid = out_valid_q;
	assign coeff       = out_q.coeff;
	assign coeff_index = out_q.coeff_index;
	assign last        = out_q.last;

endmodule
